/* rtl/core/tmsd_pkg.sv */
package tmsd_pkg;

    // configuration register indexes
    localparam logic CFG_SENSITIVITY = 1'b0;
    localparam logic CFG_PARKING     = 1'b1;

    // sensitivity codes
    localparam logic [1:0] SENS_OFF    = 2'd0;
    localparam logic [1:0] SENS_LOW    = 2'd1;
    localparam logic [1:0] SENS_MEDIUM = 2'd2;
    localparam logic [1:0] SENS_HIGH   = 2'd3;

    // operation codes
    localparam logic OP_CRASH   = 1'b0;
    localparam logic OP_PARKING = 1'b1;

    // crash thresholds per sensitivity
    localparam logic [9:0] THR_LOW    = 10'h095;
    localparam logic [9:0] THR_MEDIUM = 10'h085;
    localparam logic [9:0] THR_HIGH   = 10'h065;

    localparam logic [9:0] PARK_THR_RESET = 10'h020;

    // front to back queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one classified sample waiting for the back end
    typedef struct packed {
        logic              checked;
        logic              need_two;
        logic [9:0]        thr;
        logic signed [9:0] x;
        logic signed [9:0] y;
        logic signed [9:0] z;
    } t_job;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

/* rtl/core/tmsd_front.sv */
module tmsd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_index,
    input  logic [9:0]          i_cfg_data,
    input  logic                i_valid,
    input  logic                i_operation,
    input  logic [9:0]          i_x_raw,
    input  logic [9:0]          i_y_raw,
    input  logic [9:0]          i_z_raw,
    input  tmsd_pkg::t_qstat    i_qstat,
    output logic                o_stall,
    output logic                o_push,
    output tmsd_pkg::t_job      o_job
);

    logic [1:0] r_sens;
    logic [9:0] r_park_thr;

    // codes of 512 and up map to code - 1023, which is code + 1 modulo 1024
    function automatic logic signed [9:0] decode_axis(input logic [9:0] raw);
        logic [9:0] v;
        v = raw[9] ? (raw + 10'd1) : raw;
        return $signed(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens     <= tmsd_pkg::SENS_OFF;
            r_park_thr <= tmsd_pkg::PARK_THR_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tmsd_pkg::CFG_SENSITIVITY: r_sens     <= i_cfg_data[1:0];
                tmsd_pkg::CFG_PARKING:     r_park_thr <= i_cfg_data;
                default:                   r_sens     <= r_sens;
            endcase
        end
    end

    assign o_stall = i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

    always_comb begin
        o_job.x        = decode_axis(i_x_raw);
        o_job.y        = decode_axis(i_y_raw);
        o_job.z        = decode_axis(i_z_raw);
        o_job.checked  = 1'b1;
        o_job.need_two = 1'b0;
        o_job.thr      = r_park_thr;
        if (i_operation == tmsd_pkg::OP_CRASH) begin
            o_job.need_two = 1'b1;
            case (r_sens)
                tmsd_pkg::SENS_LOW:    o_job.thr = tmsd_pkg::THR_LOW;
                tmsd_pkg::SENS_MEDIUM: o_job.thr = tmsd_pkg::THR_MEDIUM;
                tmsd_pkg::SENS_HIGH:   o_job.thr = tmsd_pkg::THR_HIGH;
                default: begin
                    o_job.thr     = '0;
                    o_job.checked = 1'b0;
                end
            endcase
        end
    end

endmodule

/* rtl/core/tmsd_queue.sv */
module tmsd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tmsd_pkg::t_job      i_job,
    input  logic                i_pop,
    output tmsd_pkg::t_job      o_job,
    output tmsd_pkg::t_qstat    o_qstat
);

    tmsd_pkg::t_job                r_mem [tmsd_pkg::QDEPTH];
    logic [tmsd_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [tmsd_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [tmsd_pkg::QCNT_W-1:0]   r_count;
    logic [tmsd_pkg::QPTR_W-1:0]   n_wr_ptr;
    logic [tmsd_pkg::QPTR_W-1:0]   n_rd_ptr;

    localparam logic [tmsd_pkg::QPTR_W-1:0] LAST_PTR = tmsd_pkg::QPTR_W'(tmsd_pkg::QDEPTH - 1);

    assign n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_job         = r_mem[r_rd_ptr];
    assign o_qstat.full  = (r_count == tmsd_pkg::QCNT_W'(tmsd_pkg::QDEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule

/* rtl/core/tmsd_back.sv */
module tmsd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tmsd_pkg::t_job      i_job,
    input  tmsd_pkg::t_qstat    i_qstat,
    input  logic                i_stall,
    output logic                o_pop,
    output logic                o_valid,
    output logic                o_triggered,
    output logic                o_checked,
    output logic [1:0]          o_axes_over,
    output logic signed [9:0]   o_x_value,
    output logic signed [9:0]   o_y_value,
    output logic signed [9:0]   o_z_value
);

    logic signed [9:0] r_prev_x;
    logic signed [9:0] r_prev_y;
    logic signed [9:0] r_prev_z;
    logic              r_valid;
    logic              r_triggered;
    logic              r_checked;
    logic [1:0]        r_axes_over;
    logic signed [9:0] r_x;
    logic signed [9:0] r_y;
    logic signed [9:0] r_z;

    logic              over_x;
    logic              over_y;
    logic              over_z;
    logic [1:0]        n_count;
    logic              n_trig;

    function automatic logic [9:0] abs_diff(input logic signed [9:0] a,
                                            input logic signed [9:0] b);
        logic signed [10:0] d;
        d = 11'(a) - 11'(b);
        return d[10] ? 10'(-d) : d[9:0];
    endfunction

    assign over_x  = abs_diff(i_job.x, r_prev_x) > i_job.thr;
    assign over_y  = abs_diff(i_job.y, r_prev_y) > i_job.thr;
    assign over_z  = abs_diff(i_job.z, r_prev_z) > i_job.thr;
    assign n_count = i_job.checked ? (2'(over_x) + 2'(over_y) + 2'(over_z)) : 2'd0;
    assign n_trig  = i_job.need_two ? (n_count >= 2'd2) : (n_count != 2'd0);

    assign o_pop = !i_qstat.empty && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_prev_z <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
            if (o_pop && i_job.checked) begin
                r_prev_x <= i_job.x;
                r_prev_y <= i_job.y;
                r_prev_z <= i_job.z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_triggered <= n_trig;
            r_checked   <= i_job.checked;
            r_axes_over <= n_count;
            r_x         <= i_job.x;
            r_y         <= i_job.y;
            r_z         <= i_job.z;
        end
    end

    assign o_valid     = r_valid;
    assign o_triggered = r_triggered;
    assign o_checked   = r_checked;
    assign o_axes_over = r_axes_over;
    assign o_x_value   = r_x;
    assign o_y_value   = r_y;
    assign o_z_value   = r_z;

endmodule

/* rtl/core/triaxial_motion_shock_detector_core.sv */
// three-axis motion and shock detector: each sample transaction carries a crash or parking
// check and three raw 10-bit axis codes; the block decodes them to signed values, compares
// each axis change against the previous checked sample and reports how many axes moved too
// far and whether that triggers (two axes in crash mode, one in parking mode). one sample
// is taken per cycle while o_stall is low; an accepted sample is written into the front-end
// queue and moves into the back-end output register when that register is empty or its
// result is being taken. while a result is stalled, the two-entry queue between front and
// back takes up to two more samples before the input stalls; the input resumes the cycle
// after the stalled result is taken.
// configuration writes are always ready and should be made only while the block is idle.
module triaxial_motion_shock_detector_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [9:0]          i_cfg_data,
    // sample input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_operation,
    input  logic [9:0]          i_x_raw,
    input  logic [9:0]          i_y_raw,
    input  logic [9:0]          i_z_raw,
    // result output channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_triggered,
    output logic                o_checked,
    output logic [1:0]          o_axes_over,
    output logic signed [9:0]   o_x_value,
    output logic signed [9:0]   o_y_value,
    output logic signed [9:0]   o_z_value
);

    tmsd_pkg::t_job   front_job;
    tmsd_pkg::t_job   head_job;
    tmsd_pkg::t_qstat qstat;
    logic             push;
    logic             pop;

    // config registers take every write in the cycle it is offered
    assign o_cfg_ready = 1'b1;

    // front: decode axes, pick threshold and trigger rule
    tmsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_x_raw     (i_x_raw),
        .i_y_raw     (i_y_raw),
        .i_z_raw     (i_z_raw),
        .i_qstat     (qstat),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_job       (front_job)
    );

    // short queue decoupling front acceptance from back-end stalls
    tmsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_qstat (qstat)
    );

    // back: compare with stored sample, update it, register the result
    tmsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_qstat     (qstat),
        .i_stall     (i_stall),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_triggered (o_triggered),
        .o_checked   (o_checked),
        .o_axes_over (o_axes_over),
        .o_x_value   (o_x_value),
        .o_y_value   (o_y_value),
        .o_z_value   (o_z_value)
    );

endmodule

/* rtl/core/tmsd_checker.sv */
module tmsd_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_valid,
    input  logic                i_stall,
    input  logic                o_triggered,
    input  logic                o_checked,
    input  logic [1:0]          o_axes_over,
    input  logic signed [9:0]   o_x_value
);

    // a held result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_x_value) && $stable(o_axes_over))
        else $error("stalled result changed");

    // a skipped check reports nothing
    a_skip_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_checked |-> !o_triggered && (o_axes_over == 2'd0))
        else $error("unchecked result shows a trigger or count");

    // a trigger needs at least one axis over the threshold
    a_trig_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_triggered |-> (o_axes_over != 2'd0))
        else $error("trigger without any axis over");

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind triaxial_motion_shock_detector_core tmsd_checker u_tmsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_triggered (o_triggered),
    .o_checked   (o_checked),
    .o_axes_over (o_axes_over),
    .o_x_value   (o_x_value)
);

/* sim/triaxial_motion_shock_detector_core_tb.sv */
`timescale 1ns / 100ps

// testbench for the three-axis motion and shock detector
// directed table first, then random sensor-like traffic under three idling regimes
module triaxial_motion_shock_detector_core_tb;

    // one result transaction as seen on the output channel
    typedef struct packed {
        logic              triggered;
        logic              checked;
        logic [1:0]        axes_over;
        logic signed [9:0] x_value;
        logic signed [9:0] y_value;
        logic signed [9:0] z_value;
    } t_shock_result;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} t_row_kind;

    // one row of the directed table: a sample or a register write
    typedef struct {
        t_row_kind     kind;
        logic          op;
        logic [9:0]    x_raw;
        logic [9:0]    y_raw;
        logic [9:0]    z_raw;
        logic          reg_idx;
        logic [9:0]    reg_data;
        bit            typed;
        t_shock_result want;
    } t_stim_row;

    localparam int SEG_ITEMS      = 85;
    localparam int STALL_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 4;
    localparam logic [1:0] SENS_ORDER [4] = '{tmsd_pkg::SENS_OFF, tmsd_pkg::SENS_LOW,
                                              tmsd_pkg::SENS_MEDIUM, tmsd_pkg::SENS_HIGH};

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index = tmsd_pkg::CFG_SENSITIVITY;
    logic [9:0]        i_cfg_data  = '0;
    logic              i_valid     = 1'b0;
    logic              o_stall;
    logic              i_operation = tmsd_pkg::OP_CRASH;
    logic [9:0]        i_x_raw     = '0;
    logic [9:0]        i_y_raw     = '0;
    logic [9:0]        i_z_raw     = '0;
    logic              o_valid;
    logic              i_stall     = 1'b0;
    logic              o_triggered;
    logic              o_checked;
    logic [1:0]        o_axes_over;
    logic signed [9:0] o_x_value;
    logic signed [9:0] o_y_value;
    logic signed [9:0] o_z_value;

    // predictor copy of the block state and registers
    logic signed [9:0] last_x, last_y, last_z;
    logic [1:0]        sens_now;
    logic [9:0]        park_thr_now;

    t_shock_result     shock_q [$];     // expected results, oldest first
    t_shock_result     head;
    t_stim_row         dir_rows [$];

    int                src_idle_pct = 0;
    int                dst_idle_pct = 0;
    int                fail_cnt     = 0;
    int                idle_cycles  = 0;

    triaxial_motion_shock_detector_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_x_raw     (i_x_raw),
        .i_y_raw     (i_y_raw),
        .i_z_raw     (i_z_raw),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_triggered (o_triggered),
        .o_checked   (o_checked),
        .o_axes_over (o_axes_over),
        .o_x_value   (o_x_value),
        .o_y_value   (o_y_value),
        .o_z_value   (o_z_value)
    );

    always #6 i_clk = ~i_clk;

    // raw code to signed axis value: codes from 512 up fold to code - 1023
    function automatic logic signed [9:0] decode_axis_code(input logic [9:0] raw);
        int v;
        v = int'(raw);
        if (v >= 512) v = v - 1023;
        return 10'(v);
    endfunction

    // full-width absolute change, never truncated
    function automatic int axis_change(input logic signed [9:0] a, input logic signed [9:0] b);
        int ia, ib;
        ia = a;
        ib = b;
        return (ia > ib) ? ia - ib : ib - ia;
    endfunction

    // works out the result of one sample and advances the stored sample
    function automatic t_shock_result predict_shock(input logic op, input logic [9:0] xr,
                                                    input logic [9:0] yr, input logic [9:0] zr);
        t_shock_result r;
        logic signed [9:0] xv, yv, zv;
        int   thr, need, over;
        logic chk;
        xv   = decode_axis_code(xr);
        yv   = decode_axis_code(yr);
        zv   = decode_axis_code(zr);
        chk  = 1'b1;
        thr  = 0;
        over = 0;
        if (op == tmsd_pkg::OP_PARKING) begin
            thr  = int'(park_thr_now);
            need = 1;
        end else begin
            need = 2;
            case (sens_now)
                tmsd_pkg::SENS_LOW:    thr = int'(tmsd_pkg::THR_LOW);
                tmsd_pkg::SENS_MEDIUM: thr = int'(tmsd_pkg::THR_MEDIUM);
                tmsd_pkg::SENS_HIGH:   thr = int'(tmsd_pkg::THR_HIGH);
                default:               chk = 1'b0;
            endcase
        end
        // sensitivity off: no comparison and the stored sample stays put
        if (chk) begin
            if (axis_change(xv, last_x) > thr) over++;
            if (axis_change(yv, last_y) > thr) over++;
            if (axis_change(zv, last_z) > thr) over++;
            last_x = xv;
            last_y = yv;
            last_z = zv;
        end
        r.triggered = chk && (over >= need);
        r.checked   = chk;
        r.axes_over = 2'(over);
        r.x_value   = xv;
        r.y_value   = yv;
        r.z_value   = zv;
        return r;
    endfunction

    function automatic t_shock_result mk_result(input logic trig, input logic chk,
                                                input logic [1:0] axes, input int xv,
                                                input int yv, input int zv);
        t_shock_result r;
        r.triggered = trig;
        r.checked   = chk;
        r.axes_over = axes;
        r.x_value   = 10'(xv);
        r.y_value   = 10'(yv);
        r.z_value   = 10'(zv);
        return r;
    endfunction

    function automatic void add_sample(input logic op, input logic [9:0] xr, input logic [9:0] yr,
                                       input logic [9:0] zr, input bit typed = 1'b0,
                                       input t_shock_result want = '0);
        t_stim_row row;
        row.kind     = ROW_SAMPLE;
        row.op       = op;
        row.x_raw    = xr;
        row.y_raw    = yr;
        row.z_raw    = zr;
        row.reg_idx  = tmsd_pkg::CFG_SENSITIVITY;
        row.reg_data = '0;
        row.typed    = typed;
        row.want     = want;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic idx, input logic [9:0] data);
        t_stim_row row;
        row.kind     = ROW_CFG;
        row.op       = tmsd_pkg::OP_CRASH;
        row.x_raw    = '0;
        row.y_raw    = '0;
        row.z_raw    = '0;
        row.reg_idx  = idx;
        row.reg_data = data;
        row.typed    = 1'b0;
        row.want     = '0;
        dir_rows.push_back(row);
    endfunction

    // random code near the stored value, so changes land around the threshold,
    // with a share of fully random codes and the alternate zero code
    function automatic logic [9:0] near_code(input logic signed [9:0] base, input int thr);
        int v;
        if ($urandom_range(3) == 0) return 10'($urandom_range(0, 1023));
        v = base;
        if ($urandom_range(1) == 1) v = v + $urandom_range(0, thr + 12);
        else                        v = v - $urandom_range(0, thr + 12);
        if (v > 511)  v = 511;
        if (v < -511) v = -511;
        if (v == 0 && $urandom_range(1) == 1) return 10'h3ff;
        return (v < 0) ? 10'(v + 1023) : 10'(v);
    endfunction

    // one sample transaction: optional gap, then hold until accepted
    task automatic send_sample(input logic op, input logic [9:0] xr, input logic [9:0] yr,
                               input logic [9:0] zr, input bit typed, input t_shock_result want);
        t_shock_result predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_x_raw     <= xr;
        i_y_raw     <= yr;
        i_z_raw     <= zr;
        do @(posedge i_clk); while (o_stall);
        // accepted at this edge; typed rows still run the predictor to keep its state
        predicted = predict_shock(op, xr, yr, zr);
        shock_q.push_back(typed ? want : predicted);
    endtask

    // register write once every pending result has come back
    task automatic write_reg(input logic idx, input logic [9:0] data);
        i_valid <= 1'b0;
        while (shock_q.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == tmsd_pkg::CFG_SENSITIVITY) sens_now = data[1:0];
        else                                  park_thr_now = data;
        // let the write channel go idle so back-to-back writes never drive it twice at one edge
        @(posedge i_clk);
    endtask

    // result side: compare each accepted transaction, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (shock_q.size() == 0) begin
                $error("result transaction with no sample pending");
                fail_cnt++;
            end else begin
                head = shock_q.pop_front();
                if (o_triggered !== head.triggered) begin
                    $error("triggered expected %0d got %0d", head.triggered, o_triggered);
                    fail_cnt++;
                end
                if (o_checked !== head.checked) begin
                    $error("checked expected %0d got %0d", head.checked, o_checked);
                    fail_cnt++;
                end
                if (o_axes_over !== head.axes_over) begin
                    $error("axes_over expected %0d got %0d", head.axes_over, o_axes_over);
                    fail_cnt++;
                end
                if (o_x_value !== head.x_value) begin
                    $error("x_value expected %0d got %0d", head.x_value, o_x_value);
                    fail_cnt++;
                end
                if (o_y_value !== head.y_value) begin
                    $error("y_value expected %0d got %0d", head.y_value, o_y_value);
                    fail_cnt++;
                end
                if (o_z_value !== head.z_value) begin
                    $error("z_value expected %0d got %0d", head.z_value, o_z_value);
                    fail_cnt++;
                end
            end
        end
        i_stall <= ($urandom_range(99) < dst_idle_pct);
    end

    // watchdog: too long without any transaction on any channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic       op;
        logic [9:0] xr, yr, zr;
        logic [9:0] park_pick;
        int         thr_hint;

        // predictor starts from the reset state
        last_x       = '0;
        last_y       = '0;
        last_z       = '0;
        sens_now     = tmsd_pkg::SENS_OFF;
        park_thr_now = tmsd_pkg::PARK_THR_RESET;

        // directed table; the stored sample starts at zero and sensitivity is off
        // crash checks with sensitivity off: unchecked, code 1023 is zero, 512 is -511
        add_sample(tmsd_pkg::OP_CRASH,   10'd1023, 10'd1023, 10'd1023, 1'b1,
                   mk_result(1'b0, 1'b0, 2'd0, 0, 0, 0));
        add_sample(tmsd_pkg::OP_CRASH,   10'd511,  10'd512,  10'd0,    1'b1,
                   mk_result(1'b0, 1'b0, 2'd0, 511, -511, 0));
        // parking check works regardless of sensitivity; stored sample still zero
        add_sample(tmsd_pkg::OP_PARKING, 10'd0,    10'd0,    10'd0,    1'b1,
                   mk_result(1'b0, 1'b1, 2'd0, 0, 0, 0));
        add_sample(tmsd_pkg::OP_PARKING, 10'd511,  10'd512,  10'd33,   1'b1,
                   mk_result(1'b1, 1'b1, 2'd3, 511, -511, 33));
        add_sample(tmsd_pkg::OP_PARKING, 10'd511,  10'd512,  10'd0);
        // largest threshold: the largest change of 1022 stays below it
        add_cfg(tmsd_pkg::CFG_PARKING, 10'd1023);
        add_sample(tmsd_pkg::OP_PARKING, 10'd512,  10'd511,  10'd0,    1'b1,
                   mk_result(1'b0, 1'b1, 2'd0, -511, 511, 0));
        // zero threshold: equal is not over, any change is
        add_cfg(tmsd_pkg::CFG_PARKING, 10'd0);
        add_sample(tmsd_pkg::OP_PARKING, 10'd512,  10'd511,  10'd0);
        add_sample(tmsd_pkg::OP_PARKING, 10'd512,  10'd511,  10'd1);
        // crash thresholds at each sensitivity, with changes on the boundary
        // and a change above 255 that must not wrap to a small value
        add_cfg(tmsd_pkg::CFG_SENSITIVITY, {8'd0, tmsd_pkg::SENS_LOW});
        add_sample(tmsd_pkg::OP_CRASH,   10'd0,    10'd0,    10'd1);
        add_sample(tmsd_pkg::OP_CRASH,   10'd266,  10'd0,    10'd1);
        add_sample(tmsd_pkg::OP_CRASH,   10'd117,  10'd0,    10'd1);
        add_sample(tmsd_pkg::OP_CRASH,   10'd117,  10'd150,  10'd152);
        add_cfg(tmsd_pkg::CFG_SENSITIVITY, {8'd0, tmsd_pkg::SENS_MEDIUM});
        add_sample(tmsd_pkg::OP_CRASH,   10'd251,  10'd150,  10'd152);
        add_sample(tmsd_pkg::OP_CRASH,   10'd251,  10'd16,   10'd18);
        add_cfg(tmsd_pkg::CFG_SENSITIVITY, {8'd0, tmsd_pkg::SENS_HIGH});
        add_sample(tmsd_pkg::OP_CRASH,   10'd1022, 10'd118,  10'd119);
        // back to off: skipped check leaves the stored sample for the parking check
        add_cfg(tmsd_pkg::CFG_SENSITIVITY, {8'd0, tmsd_pkg::SENS_OFF});
        add_sample(tmsd_pkg::OP_CRASH,   10'd300,  10'd300,  10'd300,  1'b1,
                   mk_result(1'b0, 1'b0, 2'd0, 300, 300, 300));
        add_sample(tmsd_pkg::OP_PARKING, 10'd0,    10'd0,    10'd0);
        add_cfg(tmsd_pkg::CFG_PARKING, tmsd_pkg::PARK_THR_RESET);

        // first regime: sender rarely idles, receiver mostly stalls
        src_idle_pct = 10;
        dst_idle_pct = 85;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
            end else begin
                send_sample(dir_rows[i].op, dir_rows[i].x_raw, dir_rows[i].y_raw,
                            dir_rows[i].z_raw, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // random part: three idling regimes, each walked through several settings
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 10;
                    dst_idle_pct = 85;
                end
                1: begin
                    src_idle_pct = 85;
                    dst_idle_pct = 10;
                end
                default: begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 6; seg++) begin
                // upper data bits carry noise on a sensitivity write
                write_reg(tmsd_pkg::CFG_SENSITIVITY,
                          {8'($urandom), SENS_ORDER[(seg + phase) % 4]});
                case (seg % 3)
                    0:       park_pick = 10'($urandom_range(0, 1023));
                    1:       park_pick = 10'($urandom_range(0, 200));
                    default: park_pick = (seg % 2 == 1) ? 10'd1023 : 10'd0;
                endcase
                write_reg(tmsd_pkg::CFG_PARKING, park_pick);
                repeat (SEG_ITEMS) begin
                    op = ($urandom_range(1) == 1) ? tmsd_pkg::OP_PARKING : tmsd_pkg::OP_CRASH;
                    if (op == tmsd_pkg::OP_PARKING) thr_hint = int'(park_thr_now);
                    else begin
                        case (sens_now)
                            tmsd_pkg::SENS_MEDIUM: thr_hint = int'(tmsd_pkg::THR_MEDIUM);
                            tmsd_pkg::SENS_HIGH:   thr_hint = int'(tmsd_pkg::THR_HIGH);
                            default:               thr_hint = int'(tmsd_pkg::THR_LOW);
                        endcase
                    end
                    xr = near_code(last_x, thr_hint);
                    yr = near_code(last_y, thr_hint);
                    zr = near_code(last_z, thr_hint);
                    send_sample(op, xr, yr, zr, 1'b0, '0);
                end
            end
        end

        // drain: every expected result back, then a further wait for stray results
        i_valid <= 1'b0;
        while (shock_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/tmsd_pkg.sv
rtl/core/tmsd_front.sv
rtl/core/tmsd_queue.sv
rtl/core/tmsd_back.sv
rtl/core/triaxial_motion_shock_detector_core.sv
rtl/core/tmsd_checker.sv
sim/triaxial_motion_shock_detector_core_tb.sv
